// ===== src/tff_pkg.sv =====
// Shared types and constants for the triangle transform and face normal pipeline.
package tff_pkg;

    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0 = 2'd0,
        CFG_ROW1 = 2'd1,
        CFG_ROW2 = 2'd2,
        CFG_POS  = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] ROW0_RST = 48'd16384;
    localparam logic [CFG_W-1:0] ROW1_RST = 48'd1073741824;
    localparam logic [CFG_W-1:0] ROW2_RST = 48'd70368744177664;
    localparam logic [CFG_W-1:0] POS_RST  = 48'd0;

    localparam int NW   = 30;   // normalized magnitude width
    localparam int LW   = 62;   // squared length width
    localparam int RW   = 31;   // root width
    localparam int QW   = 15;   // quotient width
    localparam int NUMW = 46;   // divider remainder width

    localparam logic [QW-1:0] ONE_Q14 = 15'd16384;

    typedef logic [15:0] t_w16;
    typedef t_w16 [8:0] t_v9;

    typedef struct packed {
        t_v9           tv;
        logic [2:0]    neg;
        logic          zero;
        logic [NW-1:0] m0;
        logic [NW-1:0] m1;
        logic [NW-1:0] m2;
    } t_side;

endpackage

// ===== src/tff_tri_if.sv =====
// Input channel carrying one triangle per beat.
interface tff_tri_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] v0_x;
    logic signed [15:0] v0_y;
    logic signed [15:0] v0_z;
    logic signed [15:0] v1_x;
    logic signed [15:0] v1_y;
    logic signed [15:0] v1_z;
    logic signed [15:0] v2_x;
    logic signed [15:0] v2_y;
    logic signed [15:0] v2_z;

    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    input ready);
    modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  output ready);
endinterface

// ===== src/tff_res_if.sv =====
// Output channel carrying the transformed triangle and its face normal.
interface tff_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_v0_x;
    logic signed [15:0] out_v0_y;
    logic signed [15:0] out_v0_z;
    logic signed [15:0] out_v1_x;
    logic signed [15:0] out_v1_y;
    logic signed [15:0] out_v1_z;
    logic signed [15:0] out_v2_x;
    logic signed [15:0] out_v2_y;
    logic signed [15:0] out_v2_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;

    modport source (output valid, out_v0_x, out_v0_y, out_v0_z, out_v1_x, out_v1_y,
                    out_v1_z, out_v2_x, out_v2_y, out_v2_z, normal_x, normal_y, normal_z,
                    input ready);
    modport sink (input valid, out_v0_x, out_v0_y, out_v0_z, out_v1_x, out_v1_y,
                  out_v1_z, out_v2_x, out_v2_y, out_v2_z, normal_x, normal_y, normal_z,
                  output ready);
endinterface

// ===== src/tff_xform.sv =====
// Vertex transform: matrix products, then rounding, offset and saturation.
module tff_xform (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  tff_pkg::t_v9             i_vin,
    input  logic [tff_pkg::CFG_W-1:0] i_row0,
    input  logic [tff_pkg::CFG_W-1:0] i_row1,
    input  logic [tff_pkg::CFG_W-1:0] i_row2,
    input  logic [tff_pkg::CFG_W-1:0] i_pos,
    output logic                     o_valid,
    output tff_pkg::t_v9             o_tv
);
    import tff_pkg::*;

    logic [CFG_W-1:0]   rows [3];
    logic signed [31:0] n_prod [27];
    logic signed [31:0] r_prod [27];
    logic               r_vld_a;
    logic               r_vld_b;
    t_v9                n_tv;
    t_v9                r_tv;

    assign rows[0] = i_row0;
    assign rows[1] = i_row1;
    assign rows[2] = i_row2;

    // Product index is vertex * 9 + output lane * 3 + input coordinate.
    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    n_prod[v*9 + j*3 + i] = $signed(rows[i][16*j +: 16])
                                          * $signed(i_vin[v*3 + i]);
                end
            end
        end
    end

    always_comb begin
        logic signed [33:0] sum;
        logic signed [33:0] rnd;
        logic signed [20:0] tot;
        for (int v = 0; v < 3; v++) begin
            for (int j = 0; j < 3; j++) begin
                sum = 34'(r_prod[v*9 + j*3]) + 34'(r_prod[v*9 + j*3 + 1])
                    + 34'(r_prod[v*9 + j*3 + 2]);
                rnd = sum + 34'sd8192;
                tot = 21'(rnd >>> 14) + 21'($signed(i_pos[16*j +: 16]));
                if (tot > 21'sd32767) begin
                    n_tv[v*3 + j] = 16'h7FFF;
                end else if (tot < -21'sd32768) begin
                    n_tv[v*3 + j] = 16'h8000;
                end else begin
                    n_tv[v*3 + j] = tot[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_tv   <= n_tv;
        end
    end

    assign o_valid = r_vld_b;
    assign o_tv    = r_tv;
endmodule

// ===== src/tff_cross.sv =====
// Edge vectors, cross product, magnitude normalization and squared length.
module tff_cross (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  tff_pkg::t_v9              i_tv,
    output logic                      o_valid,
    output logic [tff_pkg::LW-1:0]    o_l,
    output tff_pkg::t_side            o_side
);
    import tff_pkg::*;

    logic [6:0]         r_vld;
    t_v9                r_tv [6];
    logic signed [16:0] r_d1 [3];
    logic signed [16:0] r_d2 [3];
    logic signed [33:0] r_pr [6];
    logic [33:0]        r_mag [3];
    logic [2:0]         r_neg [4];
    logic               r_zero [4];
    logic [4:0]         r_sh;
    logic               r_right;
    logic [33:0]        r_mag2 [3];
    logic [NW-1:0]      r_nm [3];
    logic [NW-1:0]      r_nm2 [3];
    logic [59:0]        r_sq [3];
    logic [LW-1:0]      r_l;
    t_side              r_side;

    logic signed [16:0] n_d1 [3];
    logic signed [16:0] n_d2 [3];
    logic signed [33:0] n_pr [6];
    logic [33:0]        n_mag [3];
    logic [2:0]         n_neg;
    logic [4:0]         n_sh;
    logic               n_right;
    logic [NW-1:0]      n_nm [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_d1[j] = 17'($signed(i_tv[3 + j])) - 17'($signed(i_tv[j]));
            n_d2[j] = 17'($signed(i_tv[6 + j])) - 17'($signed(i_tv[j]));
        end
    end

    // Products for c0, c1, c2 as pairs: (a, b) with c = a - b.
    always_comb begin
        n_pr[0] = r_d1[1] * r_d2[2];
        n_pr[1] = r_d1[2] * r_d2[1];
        n_pr[2] = r_d1[2] * r_d2[0];
        n_pr[3] = r_d1[0] * r_d2[2];
        n_pr[4] = r_d1[0] * r_d2[1];
        n_pr[5] = r_d1[1] * r_d2[0];
    end

    always_comb begin
        logic signed [34:0] c;
        for (int j = 0; j < 3; j++) begin
            c = 35'(r_pr[2*j]) - 35'(r_pr[2*j + 1]);
            n_neg[j] = c[34];
            n_mag[j] = c[34] ? 34'(-c) : c[33:0];
        end
    end

    // The leading one of the OR of all magnitudes is the leading one of the largest.
    always_comb begin
        logic [33:0] orw;
        logic [5:0]  p;
        orw = r_mag[0] | r_mag[1] | r_mag[2];
        p   = 6'd0;
        for (int i = 0; i < 34; i++) begin
            if (orw[i]) begin
                p = 6'(i);
            end
        end
        n_right = (p >= 6'd30);
        n_sh    = n_right ? 5'(p - 6'd29) : 5'(6'd29 - p);
    end

    always_comb begin
        logic [33:0] t;
        for (int j = 0; j < 3; j++) begin
            t = r_right ? (r_mag2[j] >> r_sh) : (r_mag2[j] << r_sh);
            n_nm[j] = t[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tv[0]   <= i_tv;
            r_d1      <= n_d1;
            r_d2      <= n_d2;
            r_tv[1]   <= r_tv[0];
            r_pr      <= n_pr;
            r_tv[2]   <= r_tv[1];
            r_mag     <= n_mag;
            r_neg[0]  <= n_neg;
            r_zero[0] <= (n_mag[0] == '0) && (n_mag[1] == '0) && (n_mag[2] == '0);
            r_tv[3]   <= r_tv[2];
            r_mag2    <= r_mag;
            r_sh      <= n_sh;
            r_right   <= n_right;
            r_neg[1]  <= r_neg[0];
            r_zero[1] <= r_zero[0];
            r_tv[4]   <= r_tv[3];
            r_nm      <= n_nm;
            r_neg[2]  <= r_neg[1];
            r_zero[2] <= r_zero[1];
            r_tv[5]   <= r_tv[4];
            r_nm2     <= r_nm;
            r_neg[3]  <= r_neg[2];
            r_zero[3] <= r_zero[2];
            for (int j = 0; j < 3; j++) begin
                r_sq[j] <= r_nm[j] * r_nm[j];
            end
            r_l         <= LW'(r_sq[0]) + LW'(r_sq[1]) + LW'(r_sq[2]);
            r_side.tv   <= r_tv[5];
            r_side.neg  <= r_neg[3];
            r_side.zero <= r_zero[3];
            r_side.m0   <= r_nm2[0];
            r_side.m1   <= r_nm2[1];
            r_side.m2   <= r_nm2[2];
        end
    end

    assign o_valid = r_vld[6];
    assign o_l     = r_l;
    assign o_side  = r_side;
endmodule

// ===== src/tff_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module tff_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [tff_pkg::LW-1:0]  i_l,
    input  tff_pkg::t_side          i_side,
    output logic                    o_valid,
    output logic [tff_pkg::RW-1:0]  o_root,
    output tff_pkg::t_side          o_side
);
    import tff_pkg::*;

    typedef struct packed {
        logic [34:0]   rem;
        logic [RW-1:0] root;
    } t_sq;

    function automatic t_sq sq_step(input logic [34:0] rem, input logic [RW-1:0] root,
                                    input logic [1:0] two);
        logic [34:0] cur;
        logic [34:0] trial;
        t_sq         s;
        cur   = {rem[32:0], two};
        trial = {2'b00, root, 2'b01};
        if (cur >= trial) begin
            s.rem  = cur - trial;
            s.root = {root[RW-2:0], 1'b1};
        end else begin
            s.rem  = cur;
            s.root = {root[RW-2:0], 1'b0};
        end
        return s;
    endfunction

    logic [34:0]   r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [LW-1:0] r_l    [RW];
    t_side         r_side [RW];
    logic          r_vld  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [34:0]   p_rem;
        logic [RW-1:0] p_root;
        logic [LW-1:0] p_l;
        t_side         p_side;
        logic          p_vld;
        t_sq           nx;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_l    = i_l;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_l    = r_l[k-1];
            assign p_side = r_side[k-1];
            assign p_vld  = r_vld[k-1];
        end

        assign nx = sq_step(p_rem, p_root, p_l[LW-1-2*k -: 2]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= nx.rem;
                r_root[k] <= nx.root;
                r_l[k]    <= p_l;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];
endmodule

// ===== src/tff_div.sv =====
// Pipelined restoring divider for the three normal lanes, plus final formatting.
module tff_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [tff_pkg::RW-1:0]  i_root,
    input  tff_pkg::t_side          i_side,
    output logic                    o_valid,
    output tff_pkg::t_v9            o_tv,
    output tff_pkg::t_w16           o_nx,
    output tff_pkg::t_w16           o_ny,
    output tff_pkg::t_w16           o_nz
);
    import tff_pkg::*;

    logic [NUMW-1:0] r_rem  [QW][3];
    logic [QW-1:0]   r_q    [QW][3];
    logic [RW-1:0]   r_root [QW];
    t_side           r_side [QW];
    logic            r_vld  [QW];

    logic            r_fin_vld;
    t_v9             r_fin_tv;
    t_w16            r_fin_n [3];
    t_w16            fmt_n [3];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NUMW-1:0] p_rem [3];
        logic [QW-1:0]   p_q   [3];
        logic [RW-1:0]   p_root;
        t_side           p_side;
        logic            p_vld;
        logic [NUMW-1:0] n_rem [3];
        logic [QW-1:0]   n_q   [3];

        if (k == 0) begin : g_first
            // Numerator is magnitude * 2^14 plus half the root, for rounding.
            assign p_rem[0] = (NUMW'(i_side.m0) << 14) + NUMW'(i_root >> 1);
            assign p_rem[1] = (NUMW'(i_side.m1) << 14) + NUMW'(i_root >> 1);
            assign p_rem[2] = (NUMW'(i_side.m2) << 14) + NUMW'(i_root >> 1);
            assign p_q[0]   = '0;
            assign p_q[1]   = '0;
            assign p_q[2]   = '0;
            assign p_root   = i_root;
            assign p_side   = i_side;
            assign p_vld    = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_q    = r_q[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
            assign p_vld  = r_vld[k-1];
        end

        always_comb begin
            logic [NUMW-1:0] d;
            d = NUMW'(p_root) << (QW - 1 - k);
            for (int j = 0; j < 3; j++) begin
                n_q[j] = p_q[j];
                if (p_rem[j] >= d) begin
                    n_rem[j]          = p_rem[j] - d;
                    n_q[j][QW-1-k]    = 1'b1;
                end else begin
                    n_rem[j]          = p_rem[j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_root[k] <= p_root;
                r_side[k] <= p_side;
            end
        end
    end

    // A zero cross product gives the +z unit normal.
    always_comb begin : fmt
        logic [QW-1:0] qn;
        t_w16          n_norm [3];
        for (int j = 0; j < 3; j++) begin
            qn = (r_q[QW-1][j] > ONE_Q14) ? ONE_Q14 : r_q[QW-1][j];
            n_norm[j] = r_side[QW-1].neg[j] ? (16'd0 - 16'(qn)) : 16'(qn);
        end
        if (r_side[QW-1].zero) begin
            n_norm[0] = '0;
            n_norm[1] = '0;
            n_norm[2] = 16'(ONE_Q14);
        end
        fmt_n = n_norm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (i_en) begin
            r_fin_vld <= r_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin_tv <= r_side[QW-1].tv;
            r_fin_n  <= fmt_n;
        end
    end

    assign o_valid = r_fin_vld;
    assign o_tv    = r_fin_tv;
    assign o_nx    = r_fin_n[0];
    assign o_ny    = r_fin_n[1];
    assign o_nz    = r_fin_n[2];
endmodule

// ===== src/triangle_transform_face_normal.sv =====
// An accepted input beat passes through the transform, cross product and
// normalization, square root, divider and output register stages in that order.
// Throughput: one triangle per cycle; all stages advance together and hold while
// the output beat waits, so a stall neither drops nor repeats a beat.
// Reset: clears every stage's valid flag and loads the identity matrix and a zero
// position.
module triangle_transform_face_normal (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tff_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tff_pkg::CFG_W-1:0]     i_cfg_data,
    tff_tri_if.sink                       i_tri,
    tff_res_if.source                     o_res
);
    import tff_pkg::*;

    logic [CFG_W-1:0] r_row0;
    logic [CFG_W-1:0] r_row1;
    logic [CFG_W-1:0] r_row2;
    logic [CFG_W-1:0] r_pos;

    logic          en;
    t_v9           vin;
    logic          xf_valid;
    t_v9           xf_tv;
    logic          cr_valid;
    logic [LW-1:0] cr_l;
    t_side         cr_side;
    logic          sq_valid;
    logic [RW-1:0] sq_root;
    t_side         sq_side;
    logic          dv_valid;
    t_v9           dv_tv;
    t_w16          dv_nx;
    t_w16          dv_ny;
    t_w16          dv_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= ROW0_RST;
            r_row1 <= ROW1_RST;
            r_row2 <= ROW2_RST;
            r_pos  <= POS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW0: r_row0 <= i_cfg_data;
                CFG_ROW1: r_row1 <= i_cfg_data;
                CFG_ROW2: r_row2 <= i_cfg_data;
                CFG_POS:  r_pos  <= i_cfg_data;
                default:  r_pos  <= r_pos;
            endcase
        end
    end

    // The whole pipeline moves when the output stage is empty or being drained.
    assign en          = !dv_valid || o_res.ready;
    assign i_tri.ready = en;

    assign vin[0] = i_tri.v0_x;
    assign vin[1] = i_tri.v0_y;
    assign vin[2] = i_tri.v0_z;
    assign vin[3] = i_tri.v1_x;
    assign vin[4] = i_tri.v1_y;
    assign vin[5] = i_tri.v1_z;
    assign vin[6] = i_tri.v2_x;
    assign vin[7] = i_tri.v2_y;
    assign vin[8] = i_tri.v2_z;

    tff_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_tri.valid),
        .i_vin   (vin),
        .i_row0  (r_row0),
        .i_row1  (r_row1),
        .i_row2  (r_row2),
        .i_pos   (r_pos),
        .o_valid (xf_valid),
        .o_tv    (xf_tv)
    );

    tff_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (xf_valid),
        .i_tv    (xf_tv),
        .o_valid (cr_valid),
        .o_l     (cr_l),
        .o_side  (cr_side)
    );

    tff_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cr_valid),
        .i_l     (cr_l),
        .i_side  (cr_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    tff_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_valid (dv_valid),
        .o_tv    (dv_tv),
        .o_nx    (dv_nx),
        .o_ny    (dv_ny),
        .o_nz    (dv_nz)
    );

    assign o_res.valid    = dv_valid;
    assign o_res.out_v0_x = dv_tv[0];
    assign o_res.out_v0_y = dv_tv[1];
    assign o_res.out_v0_z = dv_tv[2];
    assign o_res.out_v1_x = dv_tv[3];
    assign o_res.out_v1_y = dv_tv[4];
    assign o_res.out_v1_z = dv_tv[5];
    assign o_res.out_v2_x = dv_tv[6];
    assign o_res.out_v2_y = dv_tv[7];
    assign o_res.out_v2_z = dv_tv[8];
    assign o_res.normal_x = dv_nx;
    assign o_res.normal_y = dv_ny;
    assign o_res.normal_z = dv_nz;
endmodule
